/* rtl/core/dptpwm_pkg.sv */
// Types and constants shared by the dual timed pump PWM block.
package dptpwm_pkg;

   localparam int SPEED_W  = 8;
   localparam int DUTY_W   = 8;
   localparam int RUN_W    = 16;
   localparam int PERIOD_W = 10;
   localparam int HOLD_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_SET  = 2'd1,
      KIND_STOP = 2'd2,
      KIND_READ = 2'd3
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_RUN_MS        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_SPEED  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_COUNT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_COUNT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MAX      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MIN      = 3'd6;

   localparam logic [RUN_W-1:0]    RUN_MS_RST        = 16'd5000;
   localparam logic [SPEED_W-1:0]  BUTTON_SPEED_RST  = 8'd100;
   localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 10'd100;
   localparam logic [HOLD_W-1:0]   SHORT_COUNT_RST   = 8'd10;
   localparam logic [HOLD_W-1:0]   LONG_COUNT_RST    = 8'd20;
   localparam logic [DUTY_W-1:0]   DUTY_MAX_RST      = 8'd200;
   localparam logic [DUTY_W-1:0]   DUTY_MIN_RST      = 8'd40;

   localparam logic [HOLD_W-1:0]   HOLD_SAT = {HOLD_W{1'b1}};

endpackage

/* rtl/core/dptpwm_if.sv */
// Request and response channel interfaces of the dual timed pump PWM block.
interface dptpwm_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       kind;
   logic                             button_level;
   logic [dptpwm_pkg::SPEED_W-1:0]   speed_a;
   logic [dptpwm_pkg::SPEED_W-1:0]   speed_b;

   modport source (output valid, kind, button_level, speed_a, speed_b, input ready);
   modport sink   (input valid, kind, button_level, speed_a, speed_b, output ready);
endinterface

interface dptpwm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [dptpwm_pkg::DUTY_W-1:0]    duty_a;
   logic [dptpwm_pkg::DUTY_W-1:0]    duty_b;
   logic [dptpwm_pkg::SPEED_W-1:0]   status_speed_a;
   logic [dptpwm_pkg::SPEED_W-1:0]   status_speed_b;
   logic                             green_by_button;
   logic                             green_on;
   logic                             pressed;

   modport source (output valid, duty_a, duty_b, status_speed_a, status_speed_b,
                   green_by_button, green_on, pressed, input ready);
   modport sink   (input valid, duty_a, duty_b, status_speed_a, status_speed_b,
                   green_by_button, green_on, pressed, output ready);
endinterface

/* rtl/core/dual_pump_timed_pwm_with_button.sv */
// Dual timed pump PWM controller with push button debounce, top level.
// A request accepted at one edge has its response registered and valid after that edge.
// Throughput: one request per cycle; the response register stalls intake only when full
// and not being taken.
// Reset (synchronous, active high): clears pump, button and timer state and loads the
// register defaults; no clearing pass.
module dual_pump_timed_pwm_with_button #(
   parameter int PUMP_COUNT = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   dptpwm_req_if.sink                           req_bus,
   dptpwm_rsp_if.source                         rsp_bus,
   input  logic                                 csr_we,
   input  logic [dptpwm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dptpwm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SW = dptpwm_pkg::SPEED_W;
   localparam int DW = dptpwm_pkg::DUTY_W;
   localparam int RW = dptpwm_pkg::RUN_W;
   localparam int PW = dptpwm_pkg::PERIOD_W;
   localparam int HW = dptpwm_pkg::HOLD_W;

   function automatic logic [DW-1:0] duty_of(input logic [SW-1:0] speed,
                                             input logic [DW-1:0] dmax,
                                             input logic [DW-1:0] dmin);
      logic [SW:0] dbl;
      logic [SW:0] d;
      dbl = {speed, 1'b0};
      d = dbl;
      if (dbl > {1'b0, dmax}) begin
         d = {1'b0, dmax};
      end
      if (d != '0 && d < {1'b0, dmin}) begin
         d = {1'b0, dmin};
      end
      return d[DW-1:0];
   endfunction

   logic [RW-1:0] run_ms_ff;
   logic [SW-1:0] button_speed_ff;
   logic [PW-1:0] sample_period_ff;
   logic [HW-1:0] short_count_ff;
   logic [HW-1:0] long_count_ff;
   logic [DW-1:0] duty_max_ff;
   logic [DW-1:0] duty_min_ff;

   logic [PW-1:0] sample_timer_ff, sample_timer_in;
   logic          button_now_ff, button_now_in;
   logic          button_before_ff, button_before_in;
   logic [HW-1:0] hold_count_ff, hold_count_in;
   logic          green_owned_ff, green_owned_in;
   logic          green_level_ff, green_level_in;
   logic [SW-1:0] pump_speed_ff [PUMP_COUNT];
   logic [SW-1:0] pump_speed_in [PUMP_COUNT];
   logic [RW-1:0] pump_remaining_ff [PUMP_COUNT];
   logic [RW-1:0] pump_remaining_in [PUMP_COUNT];

   logic          rsp_valid_ff;
   logic [DW-1:0] duty_a_ff, duty_a_in;
   logic [DW-1:0] duty_b_ff, duty_b_in;
   logic [SW-1:0] status_a_ff, status_a_in;
   logic [SW-1:0] status_b_ff, status_b_in;
   logic          green_by_ff, green_on_ff, pressed_ff;

   logic          req_fire;
   logic          rsp_fire;
   logic [1:0]    start_hit;
   logic [SW-1:0] start_speed [2];
   logic [PW-1:0] timer_sum;
   logic          level_pressed;
   logic [HW-1:0] hold_sat;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_fire      = rsp_valid_ff && rsp_bus.ready;

   always_comb begin
      sample_timer_in  = sample_timer_ff;
      button_now_in    = button_now_ff;
      button_before_in = button_before_ff;
      hold_count_in    = hold_count_ff;
      green_owned_in   = green_owned_ff;
      green_level_in   = green_level_ff;
      pump_speed_in     = pump_speed_ff;
      pump_remaining_in = pump_remaining_ff;
      start_hit      = '0;
      start_speed[0] = '0;
      start_speed[1] = '0;
      timer_sum      = sample_timer_ff + PW'(1);
      level_pressed  = !req_bus.button_level;
      hold_sat = (hold_count_ff == dptpwm_pkg::HOLD_SAT) ? hold_count_ff
                                                        : hold_count_ff + HW'(1);
      if (req_fire) begin
         case (req_bus.kind)
            dptpwm_pkg::KIND_TICK: begin
               for (int i = 0; i < PUMP_COUNT; i++) begin
                  if (pump_remaining_ff[i] == '0) begin
                     pump_speed_in[i] = '0;
                  end else begin
                     pump_remaining_in[i] = pump_remaining_ff[i] - RW'(1);
                  end
               end
               if (timer_sum >= sample_period_ff) begin
                  sample_timer_in  = '0;
                  button_before_in = button_now_ff;
                  button_now_in    = level_pressed;
                  if (button_now_ff == level_pressed) begin
                     hold_count_in  = hold_sat;
                     green_owned_in = level_pressed;
                     if (level_pressed && hold_sat > short_count_ff) begin
                        green_level_in = 1'b1;
                     end
                     if (level_pressed && hold_sat > long_count_ff) begin
                        green_level_in = 1'b0;
                     end
                  end else begin
                     if (button_now_ff && hold_count_ff > long_count_ff) begin
                        start_hit[1]   = 1'b1;
                        start_speed[1] = button_speed_ff;
                     end else if (button_now_ff && hold_count_ff > short_count_ff) begin
                        start_hit[0]   = 1'b1;
                        start_speed[0] = button_speed_ff;
                     end
                     green_owned_in = 1'b0;
                     green_level_in = 1'b0;
                     hold_count_in  = '0;
                  end
               end else begin
                  sample_timer_in = timer_sum;
               end
            end
            dptpwm_pkg::KIND_SET: begin
               start_hit      = 2'b11;
               start_speed[0] = req_bus.speed_a;
               start_speed[1] = req_bus.speed_b;
            end
            dptpwm_pkg::KIND_STOP: begin
               start_hit = 2'b11;
            end
            default: begin
            end
         endcase
         for (int i = 0; i < PUMP_COUNT; i++) begin
            if (start_hit[i]) begin
               pump_speed_in[i]     = start_speed[i];
               pump_remaining_in[i] = run_ms_ff;
            end
         end
      end
   end

   always_comb begin
      status_a_in = pump_speed_in[0];
      status_b_in = (PUMP_COUNT >= 2) ? pump_speed_in[PUMP_COUNT-1] : '0;
      duty_a_in   = duty_of(status_a_in, duty_max_ff, duty_min_ff);
      duty_b_in   = (PUMP_COUNT >= 2) ? duty_of(status_b_in, duty_max_ff, duty_min_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ms_ff        <= dptpwm_pkg::RUN_MS_RST;
         button_speed_ff  <= dptpwm_pkg::BUTTON_SPEED_RST;
         sample_period_ff <= dptpwm_pkg::SAMPLE_PERIOD_RST;
         short_count_ff   <= dptpwm_pkg::SHORT_COUNT_RST;
         long_count_ff    <= dptpwm_pkg::LONG_COUNT_RST;
         duty_max_ff      <= dptpwm_pkg::DUTY_MAX_RST;
         duty_min_ff      <= dptpwm_pkg::DUTY_MIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            dptpwm_pkg::CSR_RUN_MS:        run_ms_ff        <= csr_wdata[RW-1:0];
            dptpwm_pkg::CSR_BUTTON_SPEED:  button_speed_ff  <= csr_wdata[SW-1:0];
            dptpwm_pkg::CSR_SAMPLE_PERIOD: sample_period_ff <= csr_wdata[PW-1:0];
            dptpwm_pkg::CSR_SHORT_COUNT:   short_count_ff   <= csr_wdata[HW-1:0];
            dptpwm_pkg::CSR_LONG_COUNT:    long_count_ff    <= csr_wdata[HW-1:0];
            dptpwm_pkg::CSR_DUTY_MAX:      duty_max_ff      <= csr_wdata[DW-1:0];
            dptpwm_pkg::CSR_DUTY_MIN:      duty_min_ff      <= csr_wdata[DW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_timer_ff  <= '0;
         button_now_ff    <= 1'b0;
         button_before_ff <= 1'b0;
         hold_count_ff    <= '0;
         green_owned_ff   <= 1'b0;
         green_level_ff   <= 1'b0;
         for (int i = 0; i < PUMP_COUNT; i++) begin
            pump_speed_ff[i]     <= '0;
            pump_remaining_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         sample_timer_ff   <= sample_timer_in;
         button_now_ff     <= button_now_in;
         button_before_ff  <= button_before_in;
         hold_count_ff     <= hold_count_in;
         green_owned_ff    <= green_owned_in;
         green_level_ff    <= green_level_in;
         pump_speed_ff     <= pump_speed_in;
         pump_remaining_ff <= pump_remaining_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         duty_a_ff   <= duty_a_in;
         duty_b_ff   <= duty_b_in;
         status_a_ff <= status_a_in;
         status_b_ff <= status_b_in;
         green_by_ff <= green_owned_in;
         green_on_ff <= green_level_in;
         pressed_ff  <= button_now_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.duty_a          = duty_a_ff;
   assign rsp_bus.duty_b          = duty_b_ff;
   assign rsp_bus.status_speed_a  = status_a_ff;
   assign rsp_bus.status_speed_b  = status_b_ff;
   assign rsp_bus.green_by_button = green_by_ff;
   assign rsp_bus.green_on        = green_on_ff;
   assign rsp_bus.pressed         = pressed_ff;

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request accepted while response held");

   a_green_owned: assert property (@(posedge clock) disable iff (reset)
      green_level_ff |-> green_owned_ff)
      else $error("green level set without button ownership");

   a_before_tracks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.kind != dptpwm_pkg::KIND_TICK) |=> $stable(button_now_ff))
      else $error("button state moved on a command");

endmodule

/* bench/dual_pump_timed_pwm_with_button_tb.sv */
// Self-checking bench for the dual timed pump PWM block: predicted status versus responses.
module dual_pump_timed_pwm_with_button_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PUMP_COUNT = 2;

   typedef struct {
      dptpwm_pkg::kind_type                kind;
      logic                                level;
      logic [dptpwm_pkg::SPEED_W-1:0]      speed_a;
      logic [dptpwm_pkg::SPEED_W-1:0]      speed_b;
   } request_type;

   typedef struct {
      logic [dptpwm_pkg::DUTY_W-1:0]       duty_a;
      logic [dptpwm_pkg::DUTY_W-1:0]       duty_b;
      logic [dptpwm_pkg::SPEED_W-1:0]      speed_a;
      logic [dptpwm_pkg::SPEED_W-1:0]      speed_b;
      logic                                green_by_button;
      logic                                green_on;
      logic                                pressed;
   } status_type;

   class pump_status_board;
      logic [dptpwm_pkg::RUN_W-1:0]    run_ticks;
      logic [dptpwm_pkg::SPEED_W-1:0]  btn_speed;
      logic [dptpwm_pkg::PERIOD_W-1:0] period;
      logic [dptpwm_pkg::HOLD_W-1:0]   short_lim;
      logic [dptpwm_pkg::HOLD_W-1:0]   long_lim;
      logic [dptpwm_pkg::DUTY_W-1:0]   duty_hi;
      logic [dptpwm_pkg::DUTY_W-1:0]   duty_lo;

      logic [dptpwm_pkg::PERIOD_W-1:0] timer;
      logic                            btn_now;
      logic                            btn_prev;
      logic [dptpwm_pkg::HOLD_W-1:0]   hold;
      logic                            green_own;
      logic                            green_lvl;
      logic [dptpwm_pkg::SPEED_W-1:0]  speed [2];
      logic [dptpwm_pkg::RUN_W-1:0]    remain [2];

      status_type          awaited_status [$];
      int                  errors;

      function new();
         run_ticks = dptpwm_pkg::RUN_MS_RST;
         btn_speed = dptpwm_pkg::BUTTON_SPEED_RST;
         period    = dptpwm_pkg::SAMPLE_PERIOD_RST;
         short_lim = dptpwm_pkg::SHORT_COUNT_RST;
         long_lim  = dptpwm_pkg::LONG_COUNT_RST;
         duty_hi   = dptpwm_pkg::DUTY_MAX_RST;
         duty_lo   = dptpwm_pkg::DUTY_MIN_RST;
         timer     = '0;
         btn_now   = 1'b0;
         btn_prev  = 1'b0;
         hold      = '0;
         green_own = 1'b0;
         green_lvl = 1'b0;
         for (int i = 0; i < 2; i++) begin
            speed[i]  = '0;
            remain[i] = '0;
         end
         errors = 0;
      endfunction

      function void write_reg(logic [dptpwm_pkg::CSR_IDX_W-1:0] idx,
                              logic [dptpwm_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            dptpwm_pkg::CSR_RUN_MS:        run_ticks = data[dptpwm_pkg::RUN_W-1:0];
            dptpwm_pkg::CSR_BUTTON_SPEED:  btn_speed = data[dptpwm_pkg::SPEED_W-1:0];
            dptpwm_pkg::CSR_SAMPLE_PERIOD: period    = data[dptpwm_pkg::PERIOD_W-1:0];
            dptpwm_pkg::CSR_SHORT_COUNT:   short_lim = data[dptpwm_pkg::HOLD_W-1:0];
            dptpwm_pkg::CSR_LONG_COUNT:    long_lim  = data[dptpwm_pkg::HOLD_W-1:0];
            dptpwm_pkg::CSR_DUTY_MAX:      duty_hi   = data[dptpwm_pkg::DUTY_W-1:0];
            dptpwm_pkg::CSR_DUTY_MIN:      duty_lo   = data[dptpwm_pkg::DUTY_W-1:0];
            default: ;
         endcase
      endfunction

      function void launch(int which, logic [dptpwm_pkg::SPEED_W-1:0] spd);
         if (which >= PUMP_COUNT)
            return;
         speed[which]  = spd;
         remain[which] = run_ticks;
      endfunction

      function logic [dptpwm_pkg::DUTY_W-1:0] duty_for(logic [dptpwm_pkg::SPEED_W-1:0] spd);
         logic [dptpwm_pkg::SPEED_W:0] d;
         d = {spd, 1'b0};
         if (d > {1'b0, duty_hi})
            d = {1'b0, duty_hi};
         if (d != '0 && d < {1'b0, duty_lo})
            d = {1'b0, duty_lo};
         return d[dptpwm_pkg::DUTY_W-1:0];
      endfunction

      function void sample_button(logic level);
         btn_prev = btn_now;
         btn_now  = ~level;
         if (btn_prev == btn_now) begin
            if (hold != dptpwm_pkg::HOLD_SAT)
               hold = hold + 1'b1;
            green_own = btn_now;
            if (btn_now && hold > short_lim)
               green_lvl = 1'b1;
            if (btn_now && hold > long_lim)
               green_lvl = 1'b0;
         end else begin
            if (btn_prev && hold > long_lim)
               launch(1, btn_speed);
            else if (btn_prev && hold > short_lim)
               launch(0, btn_speed);
            green_own = 1'b0;
            green_lvl = 1'b0;
            hold      = '0;
         end
      endfunction

      function void advance_tick(logic level);
         for (int i = 0; i < PUMP_COUNT; i++) begin
            if (remain[i] == '0)
               speed[i] = '0;
            else
               remain[i] = remain[i] - 1'b1;
         end
         timer = timer + 1'b1;
         if (timer >= period) begin
            timer = '0;
            sample_button(level);
         end
      endfunction

      function void note_request(request_type r);
         status_type s;
         case (r.kind)
            dptpwm_pkg::KIND_TICK: advance_tick(r.level);
            dptpwm_pkg::KIND_SET: begin
               launch(0, r.speed_a);
               launch(1, r.speed_b);
            end
            dptpwm_pkg::KIND_STOP: begin
               launch(0, '0);
               launch(1, '0);
            end
            default: ;
         endcase
         s.duty_a          = duty_for(speed[0]);
         s.duty_b          = (PUMP_COUNT >= 2) ? duty_for(speed[1]) : '0;
         s.speed_a         = speed[0];
         s.speed_b         = (PUMP_COUNT >= 2) ? speed[1] : '0;
         s.green_by_button = green_own;
         s.green_on        = green_lvl;
         s.pressed         = btn_now;
         awaited_status.push_back(s);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(status_type got);
         status_type want;
         if (awaited_status.size() == 0) begin
            $display("%0t: response with no request outstanding: %p", $time, got);
            errors++;
            return;
         end
         want = awaited_status.pop_front();
         compare_field("duty_a", want.duty_a, got.duty_a);
         compare_field("duty_b", want.duty_b, got.duty_b);
         compare_field("status_speed_a", want.speed_a, got.speed_a);
         compare_field("status_speed_b", want.speed_b, got.speed_b);
         compare_field("green_by_button", want.green_by_button, got.green_by_button);
         compare_field("green_on", want.green_on, got.green_on);
         compare_field("pressed", want.pressed, got.pressed);
      endfunction

      function int outstanding();
         return awaited_status.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                              csr_we;
   logic [dptpwm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [dptpwm_pkg::CSR_DATA_W-1:0] csr_wdata;

   dptpwm_req_if req_bus ();
   dptpwm_rsp_if rsp_bus ();

   pump_status_board board;
   int burst_left;

   dual_pump_timed_pwm_with_button #(
      .PUMP_COUNT (PUMP_COUNT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic write_reg(input logic [dptpwm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dptpwm_pkg::CSR_DATA_W-1:0] data,
                            input bit last);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(idx, data);
      if (last)
         csr_we <= 1'b0;
   endtask

   task automatic apply_settings(input logic [15:0] run, bspeed, period, shrt, lng, dmax, dmin);
      write_reg(dptpwm_pkg::CSR_RUN_MS, run, 1'b0);
      write_reg(dptpwm_pkg::CSR_BUTTON_SPEED, bspeed, 1'b0);
      write_reg(dptpwm_pkg::CSR_SAMPLE_PERIOD, period, 1'b0);
      write_reg(dptpwm_pkg::CSR_SHORT_COUNT, shrt, 1'b0);
      write_reg(dptpwm_pkg::CSR_LONG_COUNT, lng, 1'b0);
      write_reg(dptpwm_pkg::CSR_DUTY_MAX, dmax, 1'b0);
      write_reg(dptpwm_pkg::CSR_DUTY_MIN, dmin, 1'b1);
   endtask

   task automatic offer(input dptpwm_pkg::kind_type k, input logic lvl,
                        input logic [dptpwm_pkg::SPEED_W-1:0] sa,
                        input logic [dptpwm_pkg::SPEED_W-1:0] sb);
      int gap;
      request_type r;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= k;
      req_bus.button_level <= lvl;
      req_bus.speed_a      <= sa;
      req_bus.speed_b      <= sb;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      r.kind    = k;
      r.level   = lvl;
      r.speed_a = sa;
      r.speed_b = sb;
      board.note_request(r);
      burst_left--;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (board.outstanding() != 0)
         @(posedge clock);
   endtask

   task automatic press_sequence(input int n, input bit saturate);
      int sent;
      int run;
      int spp;
      int pick;
      bit clean;
      logic lvl;
      sent = 0;
      lvl  = 1'b1;
      spp  = (board.period > 1) ? int'(board.period) : 1;
      while (sent < n) begin
         lvl   = ~lvl;
         clean = saturate && !lvl;
         run   = clean ? 300 * spp : $urandom_range(1, int'(board.long_lim) + 6) * spp;
         if (clean)
            saturate = 1'b0;
         for (int i = 0; i < run && sent < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
               offer(dptpwm_pkg::kind_type'($urandom_range(1, 3)), 1'($urandom),
                     8'($urandom), 8'($urandom));
            else if (pick < 13 && !clean)
               offer(dptpwm_pkg::KIND_TICK, ~lvl, 8'($urandom), 8'($urandom));
            else
               offer(dptpwm_pkg::KIND_TICK, lvl, 8'($urandom), 8'($urandom));
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         board.check_response(status_type'{rsp_bus.duty_a, rsp_bus.duty_b,
                                           rsp_bus.status_speed_a, rsp_bus.status_speed_b,
                                           rsp_bus.green_by_button, rsp_bus.green_on,
                                           rsp_bus.pressed});
   end

   // hold off long enough to fill the block, then stall on a pattern of its own
   initial begin
      int mode;
      int len;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0 || req_bus.valid !== 1'b1)
         @(posedge clock);
      repeat (60) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 9);
         len  = $urandom_range(5, 40);
         for (int k = 0; k < len; k++) begin
            @(posedge clock);
            if (mode < 4)
               rsp_bus.ready <= 1'b1;
            else if (mode < 8)
               rsp_bus.ready <= 1'($urandom);
            else if (mode == 8)
               rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            else
               rsp_bus.ready <= 1'b0;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      board = new();
      burst_left = 0;
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= dptpwm_pkg::CSR_RUN_MS;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.kind         <= dptpwm_pkg::KIND_READ;
      req_bus.button_level <= 1'b1;
      req_bus.speed_a      <= '0;
      req_bus.speed_b      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: clamping, full-width doubling, ignored fields
      offer(dptpwm_pkg::KIND_READ, 1'b0, 8'd255, 8'd255);
      offer(dptpwm_pkg::KIND_SET, 1'b0, 8'd255, 8'd255);
      offer(dptpwm_pkg::KIND_SET, 1'b1, 8'd0, 8'd1);
      offer(dptpwm_pkg::KIND_SET, 1'b1, 8'd19, 8'd20);
      offer(dptpwm_pkg::KIND_SET, 1'b0, 8'd100, 8'd128);
      offer(dptpwm_pkg::KIND_SET, 1'b1, 8'd127, 8'd99);
      offer(dptpwm_pkg::KIND_TICK, 1'b0, 8'd0, 8'd0);
      offer(dptpwm_pkg::KIND_TICK, 1'b1, 8'd255, 8'd0);
      offer(dptpwm_pkg::KIND_STOP, 1'b0, 8'd77, 8'd88);
      offer(dptpwm_pkg::KIND_READ, 1'b1, 8'd0, 8'd0);
      offer(dptpwm_pkg::KIND_SET, 1'b0, 8'd255, 8'd0);
      offer(dptpwm_pkg::KIND_TICK, 1'b0, 8'd170, 8'd85);
      offer(dptpwm_pkg::KIND_READ, 1'b0, 8'd85, 8'd170);
      settle();

      // zero run time, zero sample period, zero thresholds
      apply_settings(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd255, 16'd0);
      press_sequence(320, 1'b1);
      settle();

      apply_settings(16'd65534, 16'hFF00, 16'd1023, 16'd254, 16'd254, 16'd0, 16'd255);
      press_sequence(40, 1'b0);
      settle();

      // minimum above maximum
      apply_settings(16'd3, 16'd200, 16'd1, 16'd2, 16'd5, 16'd50, 16'd180);
      offer(dptpwm_pkg::KIND_SET, 1'b0, 8'd10, 8'd30);
      offer(dptpwm_pkg::KIND_SET, 1'b1, 8'd0, 8'd0);
      offer(dptpwm_pkg::KIND_SET, 1'b0, 8'd255, 8'd1);
      press_sequence(90, 1'b0);
      settle();

      repeat (3) begin
         apply_settings(16'($urandom_range(0, 40)), 16'($urandom),
                        {6'($urandom), 10'($urandom_range(0, 3))},
                        {8'($urandom), 8'($urandom_range(0, 6))},
                        {8'($urandom), 8'($urandom_range(0, 12))},
                        16'($urandom), 16'($urandom));
         press_sequence(70, 1'b0);
         settle();
      end

      repeat (5) @(posedge clock);
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* dual_pump_timed_pwm_with_button.f */
rtl/core/dptpwm_pkg.sv
rtl/core/dptpwm_if.sv
rtl/core/dual_pump_timed_pwm_with_button.sv
bench/dual_pump_timed_pwm_with_button_tb.sv
